// ----- rtl/psu_pkg.sv -----
// ----------------------------------------------------------------------------
// psu_pkg
// shared types and constants of the packed 12-bit sample unpacker
// ----------------------------------------------------------------------------
`default_nettype none

package psu_pkg;

    localparam int unsigned WORD_BITS      = 32;
    localparam int unsigned SAMPLE_BITS    = 12;
    localparam int unsigned COUNT_BITS     = 7;
    localparam int unsigned INDEX_BITS     = 6;
    localparam int unsigned MAX_RESULTS    = 3;
    localparam int unsigned DEF_MAX_SAMPLES = 64;

    typedef struct packed {
        logic [WORD_BITS-1:0]  payload_word;
        logic                  trace_start;
        logic [COUNT_BITS-1:0] sample_count;
    } psu_word_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_value;
        logic [INDEX_BITS-1:0]         sample_index;
        logic                          last_sample;
    } psu_sample_t;

endpackage

`default_nettype wire

// ----- rtl/psu_word_if.sv -----
// ----------------------------------------------------------------------------
// psu_word_if
// valid/ready channel carrying packed payload words
// ----------------------------------------------------------------------------
`default_nettype none

interface psu_word_if import psu_pkg::*; ();

    logic      valid;
    logic      ready;
    psu_word_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

// ----- rtl/psu_sample_if.sv -----
// ----------------------------------------------------------------------------
// psu_sample_if
// valid/ready channel carrying unpacked samples
// ----------------------------------------------------------------------------
`default_nettype none

interface psu_sample_if import psu_pkg::*; ();

    logic        valid;
    logic        ready;
    psu_sample_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

// ----- rtl/packed_12bit_sample_unpacker.sv -----
// ----------------------------------------------------------------------------
// packed_12bit_sample_unpacker
// unpacks 12-bit samples packed msb first in 32-bit words
// ----------------------------------------------------------------------------
// Each 32-bit word taken on packed_words yields up to three signed 12-bit
// samples on samples, one per cycle while samples.ready is high, with the
// first sample of a trace at bit 31 of the word that carries trace_start;
// the final sample of a trace is flagged and bits left after it are
// dropped. A word is held in an input register, split in one pass into a
// three-entry result register, and the results drain through the single
// result port, which sets the sustained rate (eight samples per three
// words). The next word is taken while results are still waiting. Words
// outside a trace, and a start with a count of zero, give no result.
// ----------------------------------------------------------------------------
`default_nettype none

module packed_12bit_sample_unpacker
    import psu_pkg::*;
#(
    parameter int unsigned MAX_SAMPLES = DEF_MAX_SAMPLES
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    psu_word_if.sink      packed_words,
    psu_sample_if.source  samples
);

    localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned LOAD_W = (CNT_W > COUNT_BITS) ? CNT_W : COUNT_BITS;
    localparam int unsigned STREAM_W = WORD_BITS + 8;

    typedef enum logic [1:0] {
        HELD_0,
        HELD_4,
        HELD_8
    } held_t;

    // input register
    logic        in_vld_reg;
    psu_word_t   in_reg;

    // unpacker state
    held_t                 held_reg,  held_next;
    logic [7:0]            lo_reg,    lo_next;
    logic [CNT_W-1:0]      left_reg,  left_next;
    logic [INDEX_BITS-1:0] idx_reg,   idx_next;

    // result register
    psu_sample_t buf_reg [MAX_RESULTS];
    logic [1:0]  cnt_reg;

    logic        out_fire;
    logic        move;

    held_t                 held_eff;
    logic [CNT_W-1:0]      left_eff;
    logic [INDEX_BITS-1:0] idx_eff;
    logic [LOAD_W-1:0]     count_ext;
    logic [STREAM_W-1:0]   stream;
    logic [1:0]            avail;
    logic [1:0]            emit;
    psu_sample_t           res [MAX_RESULTS];

    assign out_fire = samples.valid && samples.ready;
    assign move     = in_vld_reg && ((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_fire));

    assign packed_words.ready = !in_vld_reg || move;
    assign samples.valid      = (cnt_reg != 2'd0);
    assign samples.payload    = buf_reg[0];

    always_comb
    begin
        count_ext = LOAD_W'(in_reg.sample_count);
        if (in_reg.trace_start)
        begin
            if (count_ext > LOAD_W'(MAX_SAMPLES))
                left_eff = CNT_W'(MAX_SAMPLES);
            else
                left_eff = CNT_W'(count_ext);
            held_eff = HELD_0;
            idx_eff  = '0;
        end
        else
        begin
            left_eff = left_reg;
            held_eff = held_reg;
            idx_eff  = idx_reg;
        end

        case (held_eff)
            HELD_4:
            begin
                stream    = {lo_reg[3:0], in_reg.payload_word, 4'b0000};
                avail     = 2'd3;
                held_next = HELD_0;
                lo_next   = '0;
            end
            HELD_8:
            begin
                stream    = {lo_reg, in_reg.payload_word};
                avail     = 2'd3;
                held_next = HELD_4;
                lo_next   = {4'b0000, in_reg.payload_word[3:0]};
            end
            default:
            begin
                stream    = {in_reg.payload_word, 8'h00};
                avail     = 2'd2;
                held_next = HELD_8;
                lo_next   = in_reg.payload_word[7:0];
            end
        endcase

        if (LOAD_W'(left_eff) < LOAD_W'(avail))
            emit = 2'(left_eff);
        else
            emit = avail;

        left_next = left_eff - CNT_W'(emit);
        idx_next  = idx_eff + INDEX_BITS'(emit);

        // end of trace drops the leftover bits
        if (left_next == '0)
        begin
            held_next = HELD_0;
            lo_next   = '0;
        end

        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            res[k].sample_value = stream[STREAM_W-1-SAMPLE_BITS*k -: SAMPLE_BITS];
            res[k].sample_index = idx_eff + INDEX_BITS'(k);
            res[k].last_sample  = (LOAD_W'(left_eff) == LOAD_W'(k + 1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            held_reg   <= HELD_0;
            lo_reg     <= '0;
            left_reg   <= '0;
            idx_reg    <= '0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (packed_words.ready)
                in_vld_reg <= packed_words.valid;
            if (move)
            begin
                held_reg <= held_next;
                lo_reg   <= lo_next;
                left_reg <= left_next;
                idx_reg  <= idx_next;
                cnt_reg  <= emit;
            end
            else if (out_fire)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (packed_words.valid && packed_words.ready)
            in_reg <= packed_words.payload;
        if (move)
        begin
            buf_reg <= res;
        end
        else if (out_fire)
        begin
            for (int k = 0; k < MAX_RESULTS - 1; k++)
                buf_reg[k] <= buf_reg[k+1];
        end
    end

endmodule

`default_nettype wire
